@@ hdl/drive_command_watchdog_gate_top_assert.svh @@
// Assertion macros for the drive command watchdog gate.
// They expect signals named clk and rst in the scope of use.
`ifndef DRIVE_COMMAND_WATCHDOG_GATE_TOP_ASSERT_SVH
`define DRIVE_COMMAND_WATCHDOG_GATE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCWG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcwg assertion failed");

// Next-cycle implication, checked outside reset.
`define DCWG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcwg assertion failed");

`endif

@@ hdl/dcwg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwg_pkg
// Types and constants shared by the drive command watchdog gate.
// ----------------------------------------------------------------------------
package dcwg_pkg;

  localparam int SPEED_WIDTH  = 16;
  localparam int SOURCE_WIDTH = 3;
  localparam int LIMIT_WIDTH  = 8;
  localparam int COUNT_WIDTH  = LIMIT_WIDTH + 1;

  // Sources at or above this are not valid senders.
  localparam logic [SOURCE_WIDTH:0] SOURCE_COUNT = (SOURCE_WIDTH + 1)'(8);

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(10);
  localparam logic [SOURCE_WIDTH-1:0] NO_SOURCE = '0;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_SOURCE = 2'd2,
    KIND_ESTOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef struct packed {
    kind_t                          kind;
    logic [SOURCE_WIDTH-1:0]        source;
    logic signed [SPEED_WIDTH-1:0]  left_cmd;
    logic signed [SPEED_WIDTH-1:0]  right_cmd;
    logic                           engage;
  } in_item_t;

  typedef struct packed {
    action_t                        motor_action;
    logic signed [SPEED_WIDTH-1:0]  left_drive;
    logic signed [SPEED_WIDTH-1:0]  right_drive;
    logic                           accepted;
    logic                           timed_out;
    logic                           display_notify;
    logic                           stop_engaged;
  } out_item_t;

endpackage

@@ hdl/dcwg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwg_core
// Watchdog state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module dcwg_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dcwg_pkg::LIMIT_WIDTH-1:0]    cfg_wdata,
  input  logic                                step,
  input  dcwg_pkg::in_item_t                  item,
  output dcwg_pkg::out_item_t                 result
);
  import dcwg_pkg::*;

  logic [LIMIT_WIDTH-1:0]         timeout_limit;
  logic [SOURCE_WIDTH-1:0]        active_source, active_source_next;
  logic                           stop_latched, stop_latched_next;
  logic [COUNT_WIDTH-1:0]         tick_count, tick_count_next;
  logic signed [SPEED_WIDTH-1:0]  left_target, left_target_next;
  logic signed [SPEED_WIDTH-1:0]  right_target, right_target_next;

  logic [COUNT_WIDTH-1:0] limit_ext;
  logic [COUNT_WIDTH-1:0] limit_sat;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   src_ok;
  action_t                action;
  logic                   acc;
  logic                   notify;

  assign limit_ext = {1'b0, timeout_limit};
  assign limit_sat = limit_ext + COUNT_WIDTH'(1);
  assign count_inc = (tick_count < limit_sat) ? tick_count + COUNT_WIDTH'(1) : tick_count;
  assign src_ok    = ({1'b0, item.source} < SOURCE_COUNT);

  always_comb begin
    active_source_next = active_source;
    stop_latched_next  = stop_latched;
    tick_count_next    = tick_count;
    left_target_next   = left_target;
    right_target_next  = right_target;
    action             = ACT_NONE;
    acc                = 1'b0;
    notify             = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        tick_count_next = count_inc;
        if (count_inc >= limit_ext) begin
          left_target_next  = '0;
          right_target_next = '0;
        end
        action = stop_latched ? ACT_STOP : ACT_DRIVE;
      end
      KIND_CMD: begin
        if (src_ok && item.source == active_source && !stop_latched) begin
          left_target_next  = item.left_cmd;
          right_target_next = item.right_cmd;
          tick_count_next   = '0;
          acc               = 1'b1;
        end
      end
      KIND_SOURCE: begin
        active_source_next = src_ok ? item.source : NO_SOURCE;
        left_target_next   = '0;
        right_target_next  = '0;
        tick_count_next    = '0;
        action             = ACT_STOP;
      end
      KIND_ESTOP: begin
        if (item.engage) begin
          stop_latched_next = 1'b1;
          left_target_next  = '0;
          right_target_next = '0;
          action            = ACT_STOP;
        end else begin
          stop_latched_next = 1'b0;
          tick_count_next   = '0;
        end
        notify = 1'b1;
      end
      default: begin
        action = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    result.motor_action   = action;
    result.left_drive     = (action == ACT_DRIVE) ? left_target_next : '0;
    result.right_drive    = (action == ACT_DRIVE) ? right_target_next : '0;
    result.accepted       = acc;
    result.timed_out      = (tick_count_next >= limit_ext);
    result.display_notify = notify;
    result.stop_engaged   = stop_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= LIMIT_RESET;
      active_source <= NO_SOURCE;
      stop_latched  <= 1'b0;
      tick_count    <= '0;
      left_target   <= '0;
      right_target  <= '0;
    end else begin
      if (cfg_we) begin
        timeout_limit <= cfg_wdata;
      end
      if (step) begin
        active_source <= active_source_next;
        stop_latched  <= stop_latched_next;
        tick_count    <= tick_count_next;
        left_target   <= left_target_next;
        right_target  <= right_target_next;
      end
    end
  end

endmodule

@@ hdl/drive_command_watchdog_gate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_watchdog_gate_top
// Watchdog gate between drive speed commands and the two motor sides.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one transaction per
//   tick, speed command, source change or emergency stop. Every input
//   transaction yields exactly one output transaction on out_valid /
//   out_ready / out_data, in order.
//   Path: an accepted transaction is registered in the input stage, and its
//   result is then registered in the result stage, where out_valid goes high.
//   Throughput: one transaction per cycle; the watchdog state update is a
//   short compare/select path between the input register and the result
//   register, so a new input is taken every cycle while the output drains.
//   Stall: while out_ready is low the result register holds; one more item
//   waits in the input register, then in_ready drops.
//   Reset (rst, synchronous): both stages empty, no active source, stop
//   released, watchdog count and targets zero, timeout_limit = 10.
//   cfg_we / cfg_wdata write timeout_limit; write only while idle.
// ----------------------------------------------------------------------------
module drive_command_watchdog_gate_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dcwg_pkg::LIMIT_WIDTH-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dcwg_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dcwg_pkg::out_item_t              out_data
);
  import dcwg_pkg::*;

  // Input stage
  in_item_t  in_q;
  logic      in_q_valid;
  // Result stage
  out_item_t result;
  logic      step;

  // Process the held item whenever the result register is free or draining.
  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  dcwg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_q),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

@@ hdl/dcwg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwg_checker
// Port-level checks on the watchdog gate, bound to the top level.
// ----------------------------------------------------------------------------
`include "drive_command_watchdog_gate_top_assert.svh"

module dcwg_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  dcwg_pkg::out_item_t              out_data
);
  import dcwg_pkg::*;

  logic act_drive;
  logic speeds_zero;
  logic quiet_result;
  logic notify_ok;

  assign act_drive    = (out_data.motor_action == ACT_DRIVE);
  assign speeds_zero  = (out_data.left_drive == '0) && (out_data.right_drive == '0);
  assign quiet_result = (out_data.motor_action == ACT_NONE) && !out_data.display_notify;
  assign notify_ok    = !act_drive && !out_data.accepted;

  // Drive values only show on an apply-speeds action.
  `DCWG_ASSERT_IMPL(a_drive_zero, out_valid && !act_drive, speeds_zero)

  // A taken speed command never moves the motors or notifies the display.
  `DCWG_ASSERT_IMPL(a_accept_quiet, out_valid && out_data.accepted, quiet_result)

  // An emergency stop result is never a drive action nor an accepted command.
  `DCWG_ASSERT_IMPL(a_notify_kind, out_valid && out_data.display_notify, notify_ok)

  // Input only backs up behind a stalled result.
  `DCWG_ASSERT_IMPL(a_in_block, !in_ready, out_valid && !out_ready)

  // A stalled result stays and holds.
  `DCWG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind drive_command_watchdog_gate_top dcwg_checker u_dcwg_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drive command watchdog gate. A small scoreboard
// tracks the gate's own state (active source, stop latch, watchdog count,
// targets, timeout limit), predicts one response per accepted transaction and
// checks the responses in order. Directed corner items come first, then
// random command streams under several timeout limits, with random idling on
// both channels, a long output hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import dcwg_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;  // cycles with no transaction at all
  localparam int LONG_HOLD       = 80;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the gate state and queues the expected responses.
  // --------------------------------------------------------------------------
  class gate_scoreboard;
    logic [SOURCE_WIDTH-1:0]       active_src;
    logic                          stopped;
    logic [COUNT_WIDTH-1:0]        wd_count;
    logic signed [SPEED_WIDTH-1:0] left_tgt;
    logic signed [SPEED_WIDTH-1:0] right_tgt;
    logic [LIMIT_WIDTH-1:0]        limit;
    out_item_t                     pending_responses[$];
    int n_items, n_taken, n_timed_out, n_stops;
    int n_mismatch, n_unexpected;

    function new();
      active_src   = NO_SOURCE;
      stopped      = 1'b0;
      wd_count     = '0;
      left_tgt     = '0;
      right_tgt    = '0;
      limit        = LIMIT_RESET;
      n_items      = 0;
      n_taken      = 0;
      n_timed_out  = 0;
      n_stops      = 0;
      n_mismatch   = 0;
      n_unexpected = 0;
    endfunction

    function void set_limit(logic [LIMIT_WIDTH-1:0] value);
      limit = value;
    endfunction

    // Works out the gate's response to an accepted input transaction.
    function void log_command(in_item_t it);
      out_item_t resp;
      resp = '0;
      resp.motor_action = ACT_NONE;
      case (it.kind)
        KIND_TICK: begin
          if (wd_count < {1'b0, limit} + COUNT_WIDTH'(1)) begin
            wd_count = wd_count + COUNT_WIDTH'(1);
          end
          if (wd_count >= {1'b0, limit}) begin
            left_tgt  = '0;
            right_tgt = '0;
          end
          if (stopped) begin
            resp.motor_action = ACT_STOP;
          end else begin
            resp.motor_action = ACT_DRIVE;
            resp.left_drive   = left_tgt;
            resp.right_drive  = right_tgt;
          end
        end
        KIND_CMD: begin
          if ({1'b0, it.source} < SOURCE_COUNT && it.source == active_src && !stopped) begin
            left_tgt      = it.left_cmd;
            right_tgt     = it.right_cmd;
            wd_count      = '0;
            resp.accepted = 1'b1;
          end
        end
        KIND_SOURCE: begin
          active_src = ({1'b0, it.source} < SOURCE_COUNT) ? it.source : NO_SOURCE;
          left_tgt   = '0;
          right_tgt  = '0;
          wd_count   = '0;
          resp.motor_action = ACT_STOP;
        end
        default: begin
          if (it.engage) begin
            stopped   = 1'b1;
            left_tgt  = '0;
            right_tgt = '0;
            resp.motor_action = ACT_STOP;
          end else begin
            stopped  = 1'b0;
            wd_count = '0;
          end
          resp.display_notify = 1'b1;
        end
      endcase
      resp.timed_out    = (wd_count >= {1'b0, limit});
      resp.stop_engaged = stopped;
      n_items++;
      if (resp.accepted) n_taken++;
      if (resp.timed_out) n_timed_out++;
      if (resp.motor_action == ACT_STOP) n_stops++;
      pending_responses.push_back(resp);
    endfunction

    // Compares one output transaction with the oldest expected response.
    function void check_response(out_item_t got);
      out_item_t want;
      logic bad;
      if (pending_responses.size() == 0) begin
        n_unexpected++;
        $display("ERROR: response with nothing expected: %p", got);
        return;
      end
      want = pending_responses.pop_front();
      bad = (got.motor_action   !== want.motor_action)   ||
            (got.left_drive     !== want.left_drive)     ||
            (got.right_drive    !== want.right_drive)    ||
            (got.accepted       !== want.accepted)       ||
            (got.timed_out      !== want.timed_out)      ||
            (got.display_notify !== want.display_notify) ||
            (got.stop_engaged   !== want.stop_engaged);
      if (bad) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("ERROR: mismatch at %0t", $realtime);
          $display("  expected act=%0d l=%0d r=%0d acc=%b to=%b ntf=%b stop=%b",
                   want.motor_action, want.left_drive, want.right_drive,
                   want.accepted, want.timed_out, want.display_notify, want.stop_engaged);
          $display("  actual   act=%0d l=%0d r=%0d acc=%b to=%b ntf=%b stop=%b",
                   got.motor_action, got.left_drive, got.right_drive,
                   got.accepted, got.timed_out, got.display_notify, got.stop_engaged);
        end
      end
    endfunction

    function int failures();
      return n_mismatch + n_unexpected + pending_responses.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [LIMIT_WIDTH-1:0] cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;

  gate_scoreboard sb;

  // Idling controls shared by the drivers
  logic send_gaps;
  logic recv_stalls;
  int   long_hold;
  int   n_limits;

  drive_command_watchdog_gate_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input driver. Inputs move on the falling edge; acceptance is seen at the
  // rising edge. Valid stays high across back-to-back transactions so it is
  // never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.log_command(it);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sender pause: nothing more goes in until every response has come back.
  task automatic drain();
    quiet_input();
    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Limit writes happen only with the gate idle (after reset or a drain).
  task automatic write_limit(logic [LIMIT_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(value);
    n_limits++;
  endtask

  function automatic in_item_t make_item(kind_t k, logic [SOURCE_WIDTH-1:0] src,
                                         logic [SPEED_WIDTH-1:0] ls,
                                         logic [SPEED_WIDTH-1:0] rs, logic eng);
    in_item_t it;
    it.kind      = k;
    it.source    = src;
    it.left_cmd  = ls;
    it.right_cmd = rs;
    it.engage    = eng;
    return it;
  endfunction

  // Mostly well-formed traffic: ticks and commands from the active source,
  // with some foreign senders, source switches and stop toggles mixed in.
  function automatic in_item_t random_item();
    in_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.source    = SOURCE_WIDTH'($urandom_range(0, 7));
    it.left_cmd  = SPEED_WIDTH'($urandom);
    it.right_cmd = SPEED_WIDTH'($urandom);
    it.engage    = 1'($urandom_range(0, 1));
    if (roll < 40) begin
      it.kind = KIND_TICK;
    end else if (roll < 75) begin
      it.kind = KIND_CMD;
      if ($urandom_range(0, 99) < 85) it.source = sb.active_src;
    end else if (roll < 83) begin
      it.kind = KIND_SOURCE;
    end else begin
      it.kind   = KIND_ESTOP;
      // lean toward clearing so commands get through most of the time
      it.engage = ($urandom_range(0, 99) < 40);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Output receiver: random back-pressure per transaction, plus one long
  // hold-off when the main sequence asks for it.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 7) : 0;
      if (long_hold != 0) begin
        stall     = long_hold;
        long_hold = 0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_response(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: abort when no transaction moves on either channel for too long.
  // --------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("ERROR: no transaction for %0d cycles, giving up", WATCHDOG_CYCLES);
    $display("FAIL drive_command_watchdog_gate_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [LIMIT_WIDTH-1:0] phase_limits[6];
    int burst;

    sb          = new();
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    long_hold   = 0;
    n_limits    = 1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- Directed: reset limit of 10 ----
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));  // idle drive
    // no source active yet: source zero still matches
    send_item(make_item(KIND_CMD, 3'd0, 16'h7FFF, 16'h8000, 1'b0));
    send_item(make_item(KIND_TICK, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(make_item(KIND_CMD, 3'd3, 16'h1234, 16'h4321, 1'b1));  // not the active source
    send_item(make_item(KIND_SOURCE, 3'd7, 16'hFFFF, 16'h0000, 1'b1));
    send_item(make_item(KIND_CMD, 3'd7, 16'h8000, 16'h7FFF, 1'b0));
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(KIND_ESTOP, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1));  // engage
    send_item(make_item(KIND_CMD, 3'd7, 16'h0101, 16'h0202, 1'b0));   // blocked by stop
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));  // stop-all
    send_item(make_item(KIND_ESTOP, 3'd2, 16'h0000, 16'h0000, 1'b1)); // engage again
    send_item(make_item(KIND_ESTOP, 3'd4, 16'h0000, 16'h0000, 1'b0)); // clear
    send_item(make_item(KIND_CMD, 3'd7, 16'h5555, 16'hAAAA, 1'b0));
    send_item(make_item(KIND_TICK, 3'd7, 16'hAAAA, 16'h5555, 1'b1));
    drain();

    // ---- Directed: limit of 1, timeout on the first tick ----
    write_limit(8'd1);
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));  // count saturates
    send_item(make_item(KIND_CMD, 3'd7, 16'hFFFF, 16'h0001, 1'b0));
    send_item(make_item(KIND_TICK, 3'd1, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(KIND_CMD, 3'd7, 16'h0001, 16'hFFFF, 1'b1));
    send_item(make_item(KIND_ESTOP, 3'd1, 16'h7FFF, 16'h8000, 1'b0)); // clear while clear
    send_item(make_item(KIND_SOURCE, 3'd0, 16'h0000, 16'hFFFF, 1'b0)); // back to no source
    send_item(make_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0));
    drain();

    // ---- Random phases, one timeout limit each ----
    phase_limits = '{8'd255, 8'd2, 8'd10, 8'd1, 8'd0, 8'd200};
    phase_limits[4] = LIMIT_WIDTH'($urandom_range(3, 40));
    for (int p = 0; p < 6; p++) begin
      write_limit(phase_limits[p]);
      // phase 3 runs flat out on both sides
      send_gaps   = (p != 3);
      recv_stalls = (p != 3);

      if (p == 1) begin
        // long output hold-off while the sender keeps pushing back to back
        long_hold = LONG_HOLD;
        send_gaps = 1'b0;
        for (int i = 0; i < 40; i++) send_item(random_item());
        send_gaps = 1'b1;
      end

      for (int i = 0; i < 165; i++) send_item(random_item());

      // a run of bare ticks long enough to cross the limit, for limits up to 60 and 255
      burst = (phase_limits[p] <= 60 || phase_limits[p] == 8'd255) ?
              int'(phase_limits[p]) + 2 : 0;
      if (burst != 0) begin
        send_item(make_item(KIND_ESTOP, 3'd0, 16'h0000, 16'h0000, 1'b0));
        for (int i = 0; i < burst; i++)
          send_item(make_item(KIND_TICK, SOURCE_WIDTH'($urandom_range(0, 7)),
                              SPEED_WIDTH'($urandom), SPEED_WIDTH'($urandom),
                              1'($urandom_range(0, 1))));
      end
      drain();
    end

    // let any stray response show up before the verdict
    quiet_input();
    repeat (10) @(posedge clk);

    $display("Covered %0d transactions under %0d timeout limits (1 to 255).",
             sb.n_items, n_limits);
    $display("%0d commands taken, %0d timed-out responses, %0d stop-all responses.",
             sb.n_taken, sb.n_timed_out, sb.n_stops);
    if (sb.failures() == 0) begin
      $display("PASS drive_command_watchdog_gate_top");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", sb.n_mismatch,
               sb.n_unexpected, sb.pending_responses.size());
      $display("FAIL drive_command_watchdog_gate_top");
    end
    $finish;
  end

endmodule
